// ===== hdl/rtsb_pkg.sv =====
package rtsb_pkg;

   // Tile geometry.
   localparam int TILE_WIDTH = 32;

   // Field widths.
   localparam int COORD_W   = 16;
   localparam int HEIGHT_W  = 8;
   localparam int BYTE_W    = 8;
   localparam int OFFSET_W  = 24;
   localparam int STATUS_W  = 2;
   localparam int ROW_W     = 8;
   localparam int WIDTH_W   = 10;
   localparam int COL_W     = 12;
   localparam int PITCH_W   = 12;
   localparam int XLIM_W    = 12;
   localparam int YLIM_W    = 10;
   localparam int MODE_W    = 2;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Item kinds on the request tuser bit.
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_DATA  = 1'b1;

   // Parser modes.
   localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SKIP   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LCOUNT = 2'd2;
   localparam logic [MODE_W-1:0] MODE_LDATA  = 2'd3;

   // Tile status codes.
   localparam logic [STATUS_W-1:0] STATUS_DRAWN     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_X_CLIP    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOP_CLIP  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BOTTOM_CUT = 2'd3;

   // Register indexes (byte address is 4 times the index).
   localparam logic [1:0] REG_ROW_PITCH   = 2'd0;
   localparam logic [1:0] REG_X_LIMIT     = 2'd1;
   localparam logic [1:0] REG_Y_LIMIT     = 2'd2;
   localparam logic [1:0] REG_BASE_HEIGHT = 2'd3;

   localparam logic [PITCH_W-1:0]  PITCH_RESET  = 12'd320;
   localparam logic [XLIM_W-1:0]   XLIM_RESET   = 12'd288;
   localparam logic [YLIM_W-1:0]   YLIM_RESET   = 10'd137;
   localparam logic [HEIGHT_W-1:0] BASE_RESET   = 8'd15;

   // One result beat as it sits in the output or skid register.
   typedef struct packed {
      logic [RSP_DATA_W-1:0] tdata;
      logic                  tuser;
      logic                  tlast;
   } rsp_beat_type;

endpackage

// ===== hdl/rle_tile_span_blitter.sv =====
// Run-length tile span blitter.
//
// The request channel (req_) carries two kinds of beats, told apart by
// req_tuser: a start beat opens a tile with its position and height, and a
// data beat carries the next byte of the coded tile stream. The response
// channel (rsp_) carries pixel writes (rsp_tuser high) and one tile-end beat
// per tile (rsp_tlast high) that reports the clip status.
// Registers row_pitch, x_limit, y_limit and base_height sit on the csr_ port
// at byte addresses 0, 4, 8 and 12; write them only while no tile is open.
//
// Each request beat is decoded in the cycle it is accepted; any result it
// causes enters the response register, or the skid register while that one
// stalls. One beat can be accepted every cycle while the skid is empty; the
// path that sets this is a 16 by 12 bit multiply of the absolute row by the
// pitch followed by a three-input add. A response register plus one skid
// register part the two channels, so a request beat is still taken while a
// response waits; req_tready drops only once both are full. Reset restores the
// register defaults, closes any open tile and empties both response registers.
module rle_tile_span_blitter (
   input  logic                            clock,
   input  logic                            reset,
   // tile_x [15:0], tile_y [31:16], tile_height [39:32], data_byte [47:40]
   input  logic [rtsb_pkg::REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic                            req_tuser,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // pixel_offset [23:0], pixel_value [31:24], status [33:32], zero fill
   output logic [rtsb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // is_write
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rtsb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rtsb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rtsb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   // Configuration registers.
   logic [rtsb_pkg::PITCH_W-1:0]  row_pitch_ff;
   logic [rtsb_pkg::XLIM_W-1:0]   x_limit_ff;
   logic [rtsb_pkg::YLIM_W-1:0]   y_limit_ff;
   logic [rtsb_pkg::HEIGHT_W-1:0] base_height_ff;
   logic                          csr_write;
   logic [1:0]                    csr_index;

   // Parser state. row_abs holds the raised top row, clamped at zero, plus the row index.
   logic [rtsb_pkg::MODE_W-1:0]   mode_ff,         mode_in;
   logic [rtsb_pkg::ROW_W-1:0]    row_index_ff,    row_index_in;
   logic [rtsb_pkg::COORD_W-1:0]  row_abs_ff,      row_abs_in;
   logic [rtsb_pkg::WIDTH_W-1:0]  width_count_ff,  width_count_in;
   logic [rtsb_pkg::BYTE_W-1:0]   literal_left_ff, literal_left_in;
   logic [rtsb_pkg::COL_W-1:0]    column_pos_ff,   column_pos_in;
   logic [rtsb_pkg::COORD_W-1:0]  origin_x_ff,     origin_x_in;
   logic [rtsb_pkg::ROW_W-1:0]    rows_total_ff,   rows_total_in;
   logic [rtsb_pkg::STATUS_W-1:0] clip_status_ff,  clip_status_in;

   // Response registers.
   rtsb_pkg::rsp_beat_type out_ff, out_in, skid_ff, skid_in, res_beat;
   logic                   out_valid_ff, out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   logic                   res_valid;

   // Request fields.
   logic [rtsb_pkg::COORD_W-1:0]  tile_x;
   logic [rtsb_pkg::COORD_W-1:0]  tile_y;
   logic [rtsb_pkg::HEIGHT_W-1:0] tile_height;
   logic [rtsb_pkg::BYTE_W-1:0]   data_byte;
   logic                          req_accept;
   logic                          out_take;

   // Start decode.
   logic                          raised;
   logic [rtsb_pkg::HEIGHT_W-1:0] excess;
   logic [rtsb_pkg::COORD_W:0]    raised_top;
   logic [rtsb_pkg::COORD_W:0]    bottom_sum;
   logic                          x_clip;

   // Data decode.
   logic [rtsb_pkg::WIDTH_W-1:0]  width_sum;
   logic [rtsb_pkg::ROW_W-1:0]    row_next;
   logic                          row_visible;
   logic                          draw_ok;
   logic [27:0]                   row_base;
   logic [rtsb_pkg::OFFSET_W-1:0] pixel_offset;

   assign tile_x      = req_tdata[15:0];
   assign tile_y      = req_tdata[31:16];
   assign tile_height = req_tdata[39:32];
   assign data_byte   = req_tdata[47:40];

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign out_take   = out_valid_ff && rsp_tready;

   // ---------------------------------------------------------------
   // Configuration port: writes complete in the access cycle.
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pitch_ff   <= rtsb_pkg::PITCH_RESET;
         x_limit_ff     <= rtsb_pkg::XLIM_RESET;
         y_limit_ff     <= rtsb_pkg::YLIM_RESET;
         base_height_ff <= rtsb_pkg::BASE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            rtsb_pkg::REG_ROW_PITCH:   row_pitch_ff   <= csr_pwdata[11:0];
            rtsb_pkg::REG_X_LIMIT:     x_limit_ff     <= csr_pwdata[11:0];
            rtsb_pkg::REG_Y_LIMIT:     y_limit_ff     <= csr_pwdata[9:0];
            rtsb_pkg::REG_BASE_HEIGHT: base_height_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         rtsb_pkg::REG_ROW_PITCH:   csr_prdata = {20'd0, row_pitch_ff};
         rtsb_pkg::REG_X_LIMIT:     csr_prdata = {20'd0, x_limit_ff};
         rtsb_pkg::REG_Y_LIMIT:     csr_prdata = {22'd0, y_limit_ff};
         rtsb_pkg::REG_BASE_HEIGHT: csr_prdata = {24'd0, base_height_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Start beat: raise tall tiles and classify clipping.
   // ---------------------------------------------------------------
   assign raised     = tile_height > base_height_ff;
   assign excess     = tile_height - base_height_ff;
   assign raised_top = {tile_y[15], tile_y} - (raised ? {9'd0, excess} : 17'd0);
   assign bottom_sum = {1'b0, raised_top[15:0]} + {9'd0, tile_height};
   assign x_clip     = tile_x[15] || ({3'd0, tile_x[14:0]} >= {6'd0, x_limit_ff});

   // ---------------------------------------------------------------
   // Data beat: span arithmetic and the pixel address.
   // ---------------------------------------------------------------
   assign width_sum   = width_count_ff + {2'd0, data_byte};
   assign row_next    = row_index_ff + 8'd1;
   assign row_visible = row_abs_ff < {6'd0, y_limit_ff};
   assign draw_ok     = (clip_status_ff == rtsb_pkg::STATUS_DRAWN ||
                         clip_status_ff == rtsb_pkg::STATUS_BOTTOM_CUT) && row_visible;
   assign row_base    = {12'd0, row_abs_ff} * {16'd0, row_pitch_ff};
   assign pixel_offset = {8'd0, origin_x_ff} + {12'd0, column_pos_ff} + row_base[23:0];

   always_comb begin
      mode_in         = mode_ff;
      row_index_in    = row_index_ff;
      row_abs_in      = row_abs_ff;
      width_count_in  = width_count_ff;
      literal_left_in = literal_left_ff;
      column_pos_in   = column_pos_ff;
      origin_x_in     = origin_x_ff;
      rows_total_in   = rows_total_ff;
      clip_status_in  = clip_status_ff;
      res_valid       = 1'b0;
      res_beat        = '0;

      if (req_accept) begin
         if (req_tuser == rtsb_pkg::FUNC_START) begin
            if (x_clip) begin
               clip_status_in = rtsb_pkg::STATUS_X_CLIP;
            end else if (raised_top[16]) begin
               clip_status_in = rtsb_pkg::STATUS_TOP_CLIP;
            end else if (tile_height != 8'd0 && bottom_sum > {7'd0, y_limit_ff}) begin
               clip_status_in = rtsb_pkg::STATUS_BOTTOM_CUT;
            end else begin
               clip_status_in = rtsb_pkg::STATUS_DRAWN;
            end
            origin_x_in     = tile_x;
            row_abs_in      = raised_top[16] ? 16'd0 : raised_top[15:0];
            rows_total_in   = tile_height;
            row_index_in    = '0;
            width_count_in  = '0;
            literal_left_in = '0;
            column_pos_in   = '0;
            if (tile_height == 8'd0) begin
               // An empty tile closes at once.
               mode_in        = rtsb_pkg::MODE_IDLE;
               res_valid      = 1'b1;
               res_beat.tlast = 1'b1;
               res_beat.tdata[33:32] = clip_status_in;
            end else begin
               mode_in = rtsb_pkg::MODE_SKIP;
            end
         end else begin
            case (mode_ff)
               rtsb_pkg::MODE_SKIP: begin
                  width_count_in = width_sum;
                  if (width_sum >= 10'(rtsb_pkg::TILE_WIDTH)) begin
                     // The skip reached the tile edge: move to the next row.
                     row_index_in   = row_next;
                     row_abs_in     = row_abs_ff + 16'd1;
                     width_count_in = '0;
                     column_pos_in  = '0;
                     if (row_next >= rows_total_ff) begin
                        mode_in        = rtsb_pkg::MODE_IDLE;
                        res_valid      = 1'b1;
                        res_beat.tlast = 1'b1;
                        res_beat.tdata[33:32] = clip_status_ff;
                     end
                  end else begin
                     column_pos_in = column_pos_ff + {4'd0, data_byte};
                     mode_in       = rtsb_pkg::MODE_LCOUNT;
                  end
               end
               rtsb_pkg::MODE_LCOUNT: begin
                  width_count_in  = width_sum;
                  literal_left_in = data_byte;
                  mode_in = (data_byte != 8'd0) ? rtsb_pkg::MODE_LDATA : rtsb_pkg::MODE_SKIP;
               end
               rtsb_pkg::MODE_LDATA: begin
                  column_pos_in   = column_pos_ff + 12'd1;
                  literal_left_in = literal_left_ff - 8'd1;
                  if (literal_left_ff == 8'd1) begin
                     mode_in = rtsb_pkg::MODE_SKIP;
                  end
                  if (draw_ok) begin
                     res_valid             = 1'b1;
                     res_beat.tuser        = 1'b1;
                     res_beat.tdata[23:0]  = pixel_offset;
                     res_beat.tdata[31:24] = data_byte;
                  end
               end
               default: ;  // Data while no tile is open is dropped.
            endcase
         end
      end
   end

   // ---------------------------------------------------------------
   // Response register with a one-entry skid behind it.
   // ---------------------------------------------------------------
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         // No request is taken while the skid is full.
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || out_take) begin
            out_in       = res_beat;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res_beat;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= rtsb_pkg::MODE_IDLE;
         row_index_ff  <= '0;
         width_count_ff <= '0;
         literal_left_ff <= '0;
         column_pos_ff <= '0;
         origin_x_ff   <= '0;
         row_abs_ff    <= '0;
         rows_total_ff <= '0;
         clip_status_ff <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         row_index_ff  <= row_index_in;
         width_count_ff <= width_count_in;
         literal_left_ff <= literal_left_in;
         column_pos_ff <= column_pos_in;
         origin_x_ff   <= origin_x_in;
         row_abs_ff    <= row_abs_in;
         rows_total_ff <= rows_total_in;
         clip_status_ff <= clip_status_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.tdata;
   assign rsp_tuser  = out_ff.tuser;
   assign rsp_tlast  = out_ff.tlast;

endmodule

// ===== hdl/rtsb_checker.sv =====
module rtsb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic [rtsb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            rsp_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic                            csr_psel,
   input logic                            csr_pready
);

   // A stalled response beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response beat changed while stalled");

   // A pixel write never closes a tile and carries no status.
   a_write_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tlast &&
      rsp_tdata[33:32] == rsp_pkg_drawn())
      else $error("pixel write carries tile-end fields");

   // Reset empties the response side.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("response still valid after reset");

   // With the response register empty the skid is empty and requests flow.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with nothing pending");

   // The configuration port never waits.
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_psel |-> csr_pready)
      else $error("configuration port inserted a wait");

   function automatic logic [rtsb_pkg::STATUS_W-1:0] rsp_pkg_drawn();
      return rtsb_pkg::STATUS_DRAWN;
   endfunction

endmodule

bind rle_tile_span_blitter rtsb_checker u_rtsb_checker (.*);

// ===== tb/testbench.sv =====
// Checks the run-length tile span blitter from its stream and register
// ports. Every request beat the block accepts also goes through a decoder
// kept in this file, which holds its own copy of the parser state and the
// registers. Writes and tile-end beats that the decoder predicts wait in a
// queue, and each response beat is checked against the oldest of them.
module testbench;

   // One response beat, split into its fields.
   typedef struct packed {
      logic [rtsb_pkg::OFFSET_W-1:0] offset;
      logic [rtsb_pkg::BYTE_W-1:0]   value;
      logic                          is_write;
      logic                          tile_done;
      logic [rtsb_pkg::STATUS_W-1:0] status;
   } blit_result_type;

   // One row of the directed script. Where typed is set, the row's
   // tile-end beat is written out here instead of being taken from the
   // decoder.
   typedef struct packed {
      logic                          func;
      logic [rtsb_pkg::COORD_W-1:0]  x;
      logic [rtsb_pkg::COORD_W-1:0]  y;
      logic [rtsb_pkg::HEIGHT_W-1:0] h;
      logic [rtsb_pkg::BYTE_W-1:0]   b;
      logic                          typed;
      logic [rtsb_pkg::STATUS_W-1:0] status;
   } script_row_type;

   logic                            clock;
   logic                            reset;
   logic [rtsb_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                            req_tuser;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [rtsb_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            rsp_tlast;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [rtsb_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [rtsb_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [rtsb_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   rle_tile_span_blitter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Register copies, updated when a register write completes.
   logic [rtsb_pkg::PITCH_W-1:0]  cfg_pitch;
   logic [rtsb_pkg::XLIM_W-1:0]   cfg_xlim;
   logic [rtsb_pkg::YLIM_W-1:0]   cfg_ylim;
   logic [rtsb_pkg::HEIGHT_W-1:0] cfg_base;

   // Decoder state, mirroring the parser inside the block.
   logic [rtsb_pkg::MODE_W-1:0]   dec_mode;
   logic [rtsb_pkg::ROW_W-1:0]    dec_row;
   logic [rtsb_pkg::WIDTH_W-1:0]  dec_width;
   logic [rtsb_pkg::BYTE_W-1:0]   dec_lit;
   logic [rtsb_pkg::COL_W-1:0]    dec_col;
   int                            dec_ox;
   int                            dec_oy;
   logic [rtsb_pkg::HEIGHT_W-1:0] dec_rows;
   logic [rtsb_pkg::STATUS_W-1:0] dec_clip;

   blit_result_type pending_blits[$];

   int mismatch_count;
   int items_sent;
   int burst_left;
   bit stall_request;
   bit stall_done;

   // Travel with each request beat so that the request watcher knows
   // whether the directed script typed the expected tile end in.
   logic                          row_typed;
   logic [rtsb_pkg::STATUS_W-1:0] row_status;

   // Directed script, run with the registers at their reset values
   // (x limit 288, y limit 137, base height 15, pitch 320).
   script_row_type script [26] = '{
      // A data byte with no tile open is dropped.
      '{rtsb_pkg::FUNC_DATA,  16'd0,    16'd0,    8'd0,   8'hFF, 1'b0, rtsb_pkg::STATUS_DRAWN},
      // Zero-height tiles end at once; their status shows the clip rules.
      '{rtsb_pkg::FUNC_START, 16'hFFFF, 16'd0,    8'd0,   8'h00, 1'b1, rtsb_pkg::STATUS_X_CLIP},
      '{rtsb_pkg::FUNC_START, 16'd288,  16'd0,    8'd0,   8'h00, 1'b1, rtsb_pkg::STATUS_X_CLIP},
      '{rtsb_pkg::FUNC_START, 16'd0,    16'h8000, 8'd0,   8'h00, 1'b1,
        rtsb_pkg::STATUS_TOP_CLIP},
      '{rtsb_pkg::FUNC_START, 16'd287,  16'h7FFF, 8'd0,   8'h00, 1'b1, rtsb_pkg::STATUS_DRAWN},
      '{rtsb_pkg::FUNC_START, 16'd0,    16'd0,    8'd0,   8'h00, 1'b1, rtsb_pkg::STATUS_DRAWN},
      // A two-row tile drawn in full: skip, literal pair, closing skip,
      // then a row with an empty literal run.
      '{rtsb_pkg::FUNC_START, 16'd10,   16'd20,   8'd2,   8'h00, 1'b0, rtsb_pkg::STATUS_DRAWN},
      '{rtsb_pkg::FUNC_DATA,  16'd0,    16'd0,    8'd0,   8'd3,  1'b0, rtsb_pkg::STATUS_DRAWN},
      '{rtsb_pkg::FUNC_DATA,  16'd0,    16'd0,    8'd0,   8'd2,  1'b0, rtsb_pkg::STATUS_DRAWN},
      '{rtsb_pkg::FUNC_DATA,  16'd0,    16'd0,    8'd0,   8'h00, 1'b0, rtsb_pkg::STATUS_DRAWN},
      '{rtsb_pkg::FUNC_DATA,  16'd0,    16'd0,    8'd0,   8'hFF, 1'b0, rtsb_pkg::STATUS_DRAWN},
      '{rtsb_pkg::FUNC_DATA,  16'd0,    16'd0,    8'd0,   8'd27, 1'b0, rtsb_pkg::STATUS_DRAWN},
      '{rtsb_pkg::FUNC_DATA,  16'd0,    16'd0,    8'd0,   8'd0,  1'b0, rtsb_pkg::STATUS_DRAWN},
      '{rtsb_pkg::FUNC_DATA,  16'd0,    16'd0,    8'd0,   8'd0,  1'b0, rtsb_pkg::STATUS_DRAWN},
      '{rtsb_pkg::FUNC_DATA,  16'd0,    16'd0,    8'd0,   8'd32, 1'b1, rtsb_pkg::STATUS_DRAWN},
      // A raised tile below the y limit with a long literal run; all of
      // its writes are cut, and a new start abandons it.
      '{rtsb_pkg::FUNC_START, 16'd5,    16'd200,  8'd20,  8'h00, 1'b0, rtsb_pkg::STATUS_DRAWN},
      '{rtsb_pkg::FUNC_DATA,  16'd0,    16'd0,    8'd0,   8'd1,  1'b0, rtsb_pkg::STATUS_DRAWN},
      '{rtsb_pkg::FUNC_DATA,  16'd0,    16'd0,    8'd0,   8'd255, 1'b0, rtsb_pkg::STATUS_DRAWN},
      '{rtsb_pkg::FUNC_DATA,  16'd0,    16'd0,    8'd0,   8'h5A, 1'b0, rtsb_pkg::STATUS_DRAWN},
      // A tile raised by one row that writes one pixel before it too is
      // abandoned.
      '{rtsb_pkg::FUNC_START, 16'd100,  16'd10,   8'd16,  8'h00, 1'b0, rtsb_pkg::STATUS_DRAWN},
      '{rtsb_pkg::FUNC_DATA,  16'd0,    16'd0,    8'd0,   8'd0,  1'b0, rtsb_pkg::STATUS_DRAWN},
      '{rtsb_pkg::FUNC_DATA,  16'd0,    16'd0,    8'd0,   8'd1,  1'b0, rtsb_pkg::STATUS_DRAWN},
      '{rtsb_pkg::FUNC_DATA,  16'd0,    16'd0,    8'd0,   8'h80, 1'b0, rtsb_pkg::STATUS_DRAWN},
      // The tallest tile, raised above the top of the frame.
      '{rtsb_pkg::FUNC_START, 16'd0,    16'd0,    8'd255, 8'h00, 1'b0, rtsb_pkg::STATUS_DRAWN},
      '{rtsb_pkg::FUNC_DATA,  16'd0,    16'd0,    8'd0,   8'd40, 1'b0, rtsb_pkg::STATUS_DRAWN},
      '{rtsb_pkg::FUNC_START, 16'd0,    16'd0,    8'd0,   8'h00, 1'b1, rtsb_pkg::STATUS_DRAWN}
   };

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("[%0t] %s", $realtime, what);
      end
   endtask

   // Works out what one request beat does to the parser, and the response
   // beat it causes if any.
   task automatic decode_beat(input logic func,
                              input logic [rtsb_pkg::REQ_DATA_W-1:0] d,
                              output bit made, output blit_result_type res);
      logic signed [rtsb_pkg::COORD_W-1:0] sx;
      logic signed [rtsb_pkg::COORD_W-1:0] sy;
      logic [rtsb_pkg::HEIGHT_W-1:0]       h;
      logic [rtsb_pkg::BYTE_W-1:0]         b;
      logic [rtsb_pkg::COL_W-1:0]          at_col;
      logic [31:0]                         off32;
      int                                  dy;
      int                                  line;
      bit                                  show;
      made = 1'b0;
      res  = '0;
      b    = d[47:40];
      if (func == rtsb_pkg::FUNC_START) begin
         sx = d[15:0];
         sy = d[31:16];
         h  = d[39:32];
         // A tile taller than the base height is raised by the excess.
         dy = sy;
         if (h > cfg_base) begin
            dy = int'(sy) - (int'(h) - int'(cfg_base));
         end
         // Horizontal clipping wins over top clipping, which wins over the
         // bottom cut.
         if (sx < 0 || int'(sx) >= int'(cfg_xlim)) begin
            dec_clip = rtsb_pkg::STATUS_X_CLIP;
         end else if (dy < 0) begin
            dec_clip = rtsb_pkg::STATUS_TOP_CLIP;
         end else if (h != 0 && dy + int'(h) > int'(cfg_ylim)) begin
            dec_clip = rtsb_pkg::STATUS_BOTTOM_CUT;
         end else begin
            dec_clip = rtsb_pkg::STATUS_DRAWN;
         end
         dec_ox    = sx;
         dec_oy    = (dy < 0) ? 0 : dy;
         dec_rows  = h;
         dec_row   = '0;
         dec_width = '0;
         dec_lit   = '0;
         dec_col   = '0;
         if (h == 0) begin
            dec_mode      = rtsb_pkg::MODE_IDLE;
            made          = 1'b1;
            res.tile_done = 1'b1;
            res.status    = dec_clip;
         end else begin
            dec_mode = rtsb_pkg::MODE_SKIP;
         end
      end else begin
         case (dec_mode)
            rtsb_pkg::MODE_SKIP: begin
               dec_width = dec_width + rtsb_pkg::WIDTH_W'(b);
               if (dec_width >= rtsb_pkg::TILE_WIDTH) begin
                  // The skip closes the row.
                  dec_row   = dec_row + 1'b1;
                  dec_width = '0;
                  dec_col   = '0;
                  if (dec_row >= dec_rows) begin
                     dec_mode      = rtsb_pkg::MODE_IDLE;
                     made          = 1'b1;
                     res.tile_done = 1'b1;
                     res.status    = dec_clip;
                  end
               end else begin
                  dec_col  = dec_col + rtsb_pkg::COL_W'(b);
                  dec_mode = rtsb_pkg::MODE_LCOUNT;
               end
            end
            rtsb_pkg::MODE_LCOUNT: begin
               dec_width = dec_width + rtsb_pkg::WIDTH_W'(b);
               dec_lit   = b;
               dec_mode  = (b != 0) ? rtsb_pkg::MODE_LDATA : rtsb_pkg::MODE_SKIP;
            end
            rtsb_pkg::MODE_LDATA: begin
               line   = dec_oy + int'(dec_row);
               show   = (dec_clip == rtsb_pkg::STATUS_DRAWN ||
                         dec_clip == rtsb_pkg::STATUS_BOTTOM_CUT) &&
                        line < int'(cfg_ylim);
               at_col = dec_col;
               dec_col = dec_col + 1'b1;
               dec_lit = dec_lit - 1'b1;
               if (dec_lit == 0) begin
                  dec_mode = rtsb_pkg::MODE_SKIP;
               end
               if (show) begin
                  off32 = 32'(dec_ox) + 32'(at_col) + 32'(line) * 32'(cfg_pitch);
                  made         = 1'b1;
                  res.offset   = off32[rtsb_pkg::OFFSET_W-1:0];
                  res.value    = b;
                  res.is_write = 1'b1;
               end
            end
            default: begin
               // No tile open: the byte is dropped.
            end
         endcase
      end
   endtask

   // Offers one beat at a falling edge and returns once it is taken. The
   // sender works in bursts; before a burst it may drop tvalid for a random gap.
   task automatic push_beat(input logic func, input logic [rtsb_pkg::REQ_DATA_W-1:0] d,
                            input bit counts, input logic typed,
                            input logic [rtsb_pkg::STATUS_W-1:0] status);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_tuser  <= func;
      req_tdata  <= d;
      req_tvalid <= 1'b1;
      row_typed  <= typed;
      row_status <= status;
      do begin
         @(posedge clock);
      end while (!req_tready);
      if (counts) begin
         items_sent++;
      end
   endtask

   // Stops offering and waits until every predicted beat has come back, then
   // lets the block settle so that it is surely idle before a register write.
   task automatic drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_blits.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx,
                            input logic [rtsb_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         rtsb_pkg::REG_ROW_PITCH:   cfg_pitch = value[rtsb_pkg::PITCH_W-1:0];
         rtsb_pkg::REG_X_LIMIT:     cfg_xlim  = value[rtsb_pkg::XLIM_W-1:0];
         rtsb_pkg::REG_Y_LIMIT:     cfg_ylim  = value[rtsb_pkg::YLIM_W-1:0];
         rtsb_pkg::REG_BASE_HEIGHT: cfg_base  = value[rtsb_pkg::HEIGHT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_registers(input int pitch, input int xl, input int yl,
                                input int base);
      csr_write(rtsb_pkg::REG_ROW_PITCH, pitch);
      csr_write(rtsb_pkg::REG_X_LIMIT, xl);
      csr_write(rtsb_pkg::REG_Y_LIMIT, yl);
      csr_write(rtsb_pkg::REG_BASE_HEIGHT, base);
   endtask

   // Sends one tile. Most tiles are well formed with random content, sized
   // around the current window so that every clip case comes up. Some are
   // cut short and abandoned by the next start, some carry random bytes,
   // and a few stray bytes sometimes arrive between tiles.
   task automatic play_tile;
      logic [rtsb_pkg::BYTE_W-1:0]   stream[$];
      logic [rtsb_pkg::COORD_W-1:0]  tx;
      logic [rtsb_pkg::COORD_W-1:0]  ty;
      logic [rtsb_pkg::HEIGHT_W-1:0] th;
      int                            kind;
      int                            w;
      int                            s;
      int                            n;
      int                            limit;
      int                            r;
      bit                            tall;
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            push_beat(rtsb_pkg::FUNC_DATA, {8'($urandom), 8'($urandom), 32'($urandom)},
                      1'b0, 1'b0, rtsb_pkg::STATUS_DRAWN);
         end
      end
      tx = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                        : 16'($urandom_range(0, int'(cfg_xlim) + 4));
      ty = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                        : 16'($urandom_range(0, int'(cfg_ylim) + 40));
      r    = $urandom_range(0, 19);
      tall = (r >= 18);
      th   = (r == 17) ? 8'd0 : tall ? 8'($urandom_range(16, 72))
                                     : 8'($urandom_range(1, 4));
      kind = $urandom_range(0, 11);
      if (kind == 0) begin
         repeat ($urandom_range(1, 12)) stream.push_back(8'($urandom));
      end else begin
         for (int row = 0; row < int'(th); row++) begin
            if (tall && $urandom_range(0, 3) != 0) begin
               stream.push_back(8'($urandom_range(32, 255)));
               continue;
            end
            w = 0;
            while (1) begin
               if (w >= rtsb_pkg::TILE_WIDTH) begin
                  // A long literal run already filled the row.
                  stream.push_back(8'($urandom));
                  break;
               end
               if ($urandom_range(0, 3) == 0) begin
                  stream.push_back(8'($urandom_range(rtsb_pkg::TILE_WIDTH - w,
                                                     rtsb_pkg::TILE_WIDTH + 8 - w)));
                  break;
               end
               s = $urandom_range(0, rtsb_pkg::TILE_WIDTH - 1 - w);
               stream.push_back(8'(s));
               w += s;
               r = $urandom_range(0, 15);
               n = (r == 0) ? 0 : (r == 1) ? $urandom_range(32, 70) : $urandom_range(1, 6);
               stream.push_back(8'(n));
               w += n;
               repeat (n) stream.push_back(8'($urandom));
            end
         end
      end
      limit = (kind == 1) ? $urandom_range(0, stream.size()) : stream.size();
      push_beat(rtsb_pkg::FUNC_START, {8'($urandom), th, ty, tx}, 1'b1, 1'b0,
                rtsb_pkg::STATUS_DRAWN);
      for (int i = 0; i < limit; i++) begin
         push_beat(rtsb_pkg::FUNC_DATA, {stream[i], 8'($urandom), 32'($urandom)},
                   1'b1, 1'b0, rtsb_pkg::STATUS_DRAWN);
      end
   endtask

   // One random phase: tiles until the item budget is spent, then a
   // zero-height start so that no tile is left open for the next register
   // write, then a pause until every result is back.
   task automatic play_phase(input int budget);
      items_sent = 0;
      while (items_sent < budget) begin
         play_tile();
      end
      push_beat(rtsb_pkg::FUNC_START, {8'($urandom), 8'd0, 32'($urandom)}, 1'b1, 1'b0,
                rtsb_pkg::STATUS_DRAWN);
      drain();
   endtask

   // Request watcher: every accepted beat goes through the decoder. Rows of
   // the directed script with a typed result use that result instead.
   always @(posedge clock) begin : request_watch
      bit              made;
      blit_result_type res;
      if (!reset && req_tvalid && req_tready) begin
         decode_beat(req_tuser, req_tdata, made, res);
         if (row_typed) begin
            pending_blits.push_back('{offset: '0, value: '0, is_write: 1'b0,
                                      tile_done: 1'b1, status: row_status});
         end else if (made) begin
            pending_blits.push_back(res);
         end
      end
   end

   // Response watcher: each accepted beat must match the oldest prediction.
   always @(posedge clock) begin : response_watch
      blit_result_type got;
      blit_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{offset: rsp_tdata[23:0], value: rsp_tdata[31:24], is_write: rsp_tuser,
                 tile_done: rsp_tlast, status: rsp_tdata[33:32]};
         if (pending_blits.size() == 0) begin
            note_mismatch($sformatf("unexpected beat off=%h val=%h wr=%b done=%b st=%0d",
                                    got.offset, got.value, got.is_write, got.tile_done,
                                    got.status));
         end else begin
            want = pending_blits.pop_front();
            if (got.offset !== want.offset || got.value !== want.value ||
                got.is_write !== want.is_write || got.tile_done !== want.tile_done ||
                got.status !== want.status) begin
               note_mismatch($sformatf({"beat mismatch: expected off=%h val=%h wr=%b ",
                                        "done=%b st=%0d, got off=%h val=%h wr=%b ",
                                        "done=%b st=%0d"},
                                       want.offset, want.value, want.is_write,
                                       want.tile_done, want.status, got.offset,
                                       got.value, got.is_write, got.tile_done,
                                       got.status));
            end
         end
      end
   end

   // Receiver: switches between stretches that are always ready, ready at
   // random, and ready one cycle in four. Once asked, it holds off for a
   // long stretch so that both response registers fill and the block stops
   // taking requests while the sender keeps offering.
   initial begin : receiver
      int mode;
      int mode_left;
      rsp_tready = 1'b0;
      mode       = 0;
      mode_left  = 0;
      forever begin
         @(negedge clock);
         if (stall_request && !stall_done) begin
            stall_done = 1'b1;
            rsp_tready <= 1'b0;
            for (int held = 1; held < 400; held++) begin
               @(negedge clock);
            end
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 2);
               mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= (mode_left % 4 == 0);
            endcase
         end
      end
   end

   // Overall limit, far above the slowest correct run.
   initial begin
      #2000000;
      $display("testbench failed");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_tdata      = '0;
      req_tuser      = rtsb_pkg::FUNC_START;
      req_tvalid     = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      row_typed      = 1'b0;
      row_status     = rtsb_pkg::STATUS_DRAWN;
      mismatch_count = 0;
      items_sent     = 0;
      burst_left     = 0;
      stall_request  = 1'b0;
      stall_done     = 1'b0;
      cfg_pitch      = rtsb_pkg::PITCH_RESET;
      cfg_xlim       = rtsb_pkg::XLIM_RESET;
      cfg_ylim       = rtsb_pkg::YLIM_RESET;
      cfg_base       = rtsb_pkg::BASE_RESET;
      dec_mode       = rtsb_pkg::MODE_IDLE;
      dec_row        = '0;
      dec_width      = '0;
      dec_lit        = '0;
      dec_col        = '0;
      dec_ox         = 0;
      dec_oy         = 0;
      dec_rows       = '0;
      dec_clip       = rtsb_pkg::STATUS_DRAWN;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed script on the reset register values.
      foreach (script[i]) begin
         push_beat(script[i].func,
                   {script[i].b, script[i].h, script[i].y, script[i].x},
                   1'b1, script[i].typed, script[i].status);
      end
      drain();

      // Largest register values.
      set_registers(4095, 4095, 1023, 255);
      play_phase(250);

      // Smallest limits and base height, pitch 1: every tile is clipped or cut.
      set_registers(1, 0, 0, 0);
      play_phase(100);

      set_registers($urandom_range(1, 4095), $urandom_range(16, 4095),
                    $urandom_range(0, 1023), $urandom_range(0, 255));
      play_phase(250);

      // A roomy window with a long receiver stall early in the phase.
      set_registers(640, 600, 480, 8);
      stall_request = 1'b1;
      play_phase(200);

      repeat (10) @(posedge clock);
      if (pending_blits.size() != 0) begin
         note_mismatch($sformatf("%0d predicted beats never arrived", pending_blits.size()));
      end
      if (mismatch_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// ===== rle_tile_span_blitter.f =====
hdl/rtsb_pkg.sv
hdl/rle_tile_span_blitter.sv
hdl/rtsb_checker.sv
tb/testbench.sv
